/* hdl/qar_pkg.sv */
// Shared constants, types and helper functions for the QPSK marker-based phase resolver.
package qar_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int MARKER_SAMPLES = 64;
    localparam int MARKER_PAIRS   = MARKER_SAMPLES / 2;
    localparam int MARKER_M       = 2 * MARKER_PAIRS;
    localparam int PAIR_IDX_W     = $clog2(MARKER_PAIRS);
    localparam int CNT_W          = $clog2(MARKER_M + 1);

    localparam int THR_W   = 5;
    localparam int FRAME_W = 13;
    localparam int POS_W   = 12;

    localparam logic [FRAME_W-1:0] FRAME_MIN   = 13'd32;
    localparam logic [FRAME_W-1:0] FRAME_MAX   = 13'd4096;
    localparam logic [THR_W-1:0]   THR_RESET   = 5'd1;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 13'd1056;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // sync marker and its 90-degree rotation, first sample in the MSB
    localparam logic [63:0] SYNC_WORD   = 64'h0347_76C7_2728_95B0;
    localparam logic [63:0] SYNC_WORD90 = 64'hA921_1361_B1BE_C0DA;

    localparam logic [1:0] PH_45  = 2'd0;
    localparam logic [1:0] PH_135 = 2'd1;
    localparam logic [1:0] PH_225 = 2'd2;
    localparam logic [1:0] PH_315 = 2'd3;

    localparam int ADDR_W = 3;
    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_FRAME_PAIRS = 1'b1;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t    pi;
        sample_t    pq;
    } qar_pair_t;

    typedef struct packed {
        qar_pair_t  pair;
        logic [1:0] phase;
        logic       first;
    } qar_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qar_qstat_t;

    function automatic logic marker_bit(input logic [63:0] word, input logic [5:0] idx);
        return word[6'd63 - idx];
    endfunction

    // zero never agrees with either marker bit
    function automatic logic sign_agrees(input logic bitv, input sample_t v);
        if (bitv)
            return !v[SAMPLE_WIDTH-1] && (v != '0);
        return v[SAMPLE_WIDTH-1];
    endfunction

    function automatic sample_t sat_neg(input sample_t v);
        if (v == SAMPLE_MIN)
            return SAMPLE_MAX;
        return -v;
    endfunction

endpackage

/* hdl/qar_if.sv */
// Request channel interfaces: sample pairs in, corrected pairs out.
interface qar_in_if import qar_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_i;
    sample_t sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface qar_out_if import qar_pkg::*; ();
    logic       valid;
    logic       ready;
    sample_t    out_i;
    sample_t    out_q;
    logic [1:0] phase_code;
    logic       frame_first;

    modport source (output valid, output out_i, output out_q, output phase_code,
                    output frame_first, input ready);
    modport sink   (input valid, input out_i, input out_q, input phase_code,
                    input frame_first, output ready);
endinterface

/* hdl/qpsk_asm_phase_resolver.sv */
// Top level: QPSK phase-ambiguity resolver keyed on the frame sync marker.
// Throughput: one pair per cycle while results.ready stays high, with no bubbles between frames.
// Path: each pair waits in the MARKER_PAIRS-deep delay line until later accepted requests
// push it out, then passes through the queue write and the output register.
// Reset: no result for the first 32 accepted pairs; phase defaults to 315 degrees,
// error_threshold to 1 and frame_pairs to 1056. Input is ready right after reset.
module qpsk_asm_phase_resolver import qar_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    qar_in_if.sink            samples,
    qar_out_if.source         results,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [THR_W-1:0]   thr_reg;
    logic [FRAME_W-1:0] frame_pairs_reg;
    logic               cfg_wr;

    logic       push;
    logic       pop;
    qar_item_t  push_item;
    qar_item_t  head;
    qar_qstat_t qstat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= THR_RESET;
            frame_pairs_reg <= FRAME_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_THRESHOLD:   thr_reg         <= pwdata[THR_W-1:0];
                REG_FRAME_PAIRS: frame_pairs_reg <= pwdata[FRAME_W-1:0];
                default:         thr_reg         <= thr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_THRESHOLD:   prdata = 32'(thr_reg);
            REG_FRAME_PAIRS: prdata = 32'(frame_pairs_reg);
            default:         prdata = '0;
        endcase
    end

    qar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .err_thr   (thr_reg),
        .frame_len (frame_pairs_reg),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    qar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    qar_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .qstat   (qstat),
        .pop     (pop),
        .results (results)
    );

endmodule

/* hdl/qar_front.sv */
// Front end: frame position, marker correlation, phase decision and pair delay line.
module qar_front import qar_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    qar_in_if.sink           samples,
    input  logic [THR_W-1:0] err_thr,
    input  logic [FRAME_W-1:0] frame_len,
    input  qar_qstat_t       qstat,
    output logic             push,
    output qar_item_t        push_item
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] match_reg, match_next;
    logic [CNT_W-1:0] match90_reg, match90_next;
    logic [1:0]       phase_reg, phase_next;
    logic             warm_reg, warm_next;
    qar_pair_t        dly_reg [MARKER_PAIRS];

    logic             accept;
    logic [FRAME_W-1:0] len_c;
    logic [FRAME_W-1:0] first_pos;
    logic             in_marker;
    logic [5:0]       idx_i, idx_q;
    logic [1:0]       a_sum, b_sum;
    logic [CNT_W:0]   thr_ext;
    logic [1:0]       decided;

    assign samples.ready = !qstat.full;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        if (frame_len < FRAME_MIN)
            len_c = FRAME_MIN;
        else if (frame_len > FRAME_MAX)
            len_c = FRAME_MAX;
        else
            len_c = frame_len;
    end

    // first pair out of the line is MARKER_PAIRS positions behind, modulo frame length
    assign first_pos = (len_c == FRAME_W'(MARKER_PAIRS)) ? '0 : FRAME_W'(MARKER_PAIRS);

    assign in_marker = pos_reg < POS_W'(MARKER_PAIRS);
    assign idx_i     = {pos_reg[PAIR_IDX_W-1:0], 1'b0};
    assign idx_q     = {pos_reg[PAIR_IDX_W-1:0], 1'b1};

    always_comb
    begin
        a_sum = 2'(sign_agrees(marker_bit(SYNC_WORD, idx_i), samples.sample_i))
              + 2'(sign_agrees(marker_bit(SYNC_WORD, idx_q), samples.sample_q));
        b_sum = 2'(sign_agrees(marker_bit(SYNC_WORD90, idx_i), samples.sample_i))
              + 2'(sign_agrees(marker_bit(SYNC_WORD90, idx_q), samples.sample_q));
    end

    always_comb
    begin
        match_next   = match_reg;
        match90_next = match90_reg;
        if (in_marker)
        begin
            match_next   = (pos_reg == '0) ? CNT_W'(a_sum) : match_reg + CNT_W'(a_sum);
            match90_next = (pos_reg == '0) ? CNT_W'(b_sum) : match90_reg + CNT_W'(b_sum);
        end
    end

    assign thr_ext = (CNT_W+1)'(err_thr);

    always_comb
    begin
        if ({1'b0, match_next} + thr_ext >= (CNT_W+1)'(MARKER_M))
            decided = PH_45;
        else if ({1'b0, match_next} <= thr_ext)
            decided = PH_225;
        else if ({1'b0, match90_next} + thr_ext >= (CNT_W+1)'(MARKER_M))
            decided = PH_135;
        else
            decided = PH_315;
    end

    always_comb
    begin
        phase_next = phase_reg;
        warm_next  = warm_reg;
        if (pos_reg == POS_W'(MARKER_PAIRS - 1))
        begin
            phase_next = decided;
            warm_next  = 1'b1;
        end
        if ({1'b0, pos_reg} + 1'b1 >= len_c)
            pos_next = '0;
        else
            pos_next = pos_reg + 1'b1;
    end

    assign push                = accept && warm_reg;
    assign push_item.pair      = dly_reg[MARKER_PAIRS-1];
    assign push_item.phase     = phase_reg;
    assign push_item.first     = ({1'b0, pos_reg} == first_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            match_reg   <= '0;
            match90_reg <= '0;
            phase_reg   <= PH_315;
            warm_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            match_reg   <= match_next;
            match90_reg <= match90_next;
            phase_reg   <= phase_next;
            warm_reg    <= warm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dly_reg[0] <= '{pi: samples.sample_i, pq: samples.sample_q};
            for (int k = 1; k < MARKER_PAIRS; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

endmodule

/* hdl/qar_queue.sv */
// Short FIFO between front end and output stage.
module qar_queue import qar_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  qar_item_t  push_item,
    input  logic       pop,
    output qar_item_t  head,
    output qar_qstat_t qstat
);

    qar_item_t         ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign qstat.full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = ent_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_reg] <= push_item;
    end

endmodule

/* hdl/qar_back.sv */
// Output stage: applies the phase correction and holds the result register.
module qar_back import qar_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  qar_item_t  head,
    input  qar_qstat_t qstat,
    output logic       pop,
    qar_out_if.source  results
);

    logic       valid_reg, valid_next;
    sample_t    oi_reg, oq_reg;
    logic [1:0] ph_reg;
    logic       first_reg;

    sample_t    ri, rq;
    logic       same_sign;
    logic       load_ok;

    assign same_sign = (!head.pair.pi[SAMPLE_WIDTH-1] && head.pair.pi != '0
                        && !head.pair.pq[SAMPLE_WIDTH-1] && head.pair.pq != '0)
                    || (head.pair.pi[SAMPLE_WIDTH-1] && head.pair.pq[SAMPLE_WIDTH-1]);

    always_comb
    begin
        ri = head.pair.pi;
        rq = head.pair.pq;
        case (head.phase)
            PH_225:
            begin
                ri = sat_neg(head.pair.pi);
                rq = sat_neg(head.pair.pq);
            end
            PH_135:
            begin
                if (same_sign)
                    rq = sat_neg(head.pair.pq);
                else
                    ri = sat_neg(head.pair.pi);
            end
            PH_315:
            begin
                if (same_sign)
                    ri = sat_neg(head.pair.pi);
                else
                    rq = sat_neg(head.pair.pq);
            end
            default:
            begin
                ri = head.pair.pi;
                rq = head.pair.pq;
            end
        endcase
    end

    assign load_ok = !valid_reg || results.ready;
    assign pop     = load_ok && !qstat.empty;

    always_comb
    begin
        if (pop)
            valid_next = 1'b1;
        else if (results.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            oi_reg    <= ri;
            oq_reg    <= rq;
            ph_reg    <= head.phase;
            first_reg <= head.first;
        end
    end

    assign results.valid       = valid_reg;
    assign results.out_i       = oi_reg;
    assign results.out_q       = oq_reg;
    assign results.phase_code  = ph_reg;
    assign results.frame_first = first_reg;

endmodule

/* hdl/qar_checker.sv */
// Port-level checks for the phase resolver, bound to the top level.
module qar_checker import qar_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input sample_t    out_i,
    input sample_t    out_q,
    input logic [1:0] phase_code,
    input logic       frame_first
);

    localparam int WCNT_W = $clog2(MARKER_PAIRS + 2);

    logic [WCNT_W-1:0] seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (in_valid && in_ready && seen_reg != WCNT_W'(MARKER_PAIRS + 1))
            seen_reg <= seen_reg + 1'b1;
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_i) && $stable(out_q)
                                    && $stable(phase_code) && $stable(frame_first))
        else $error("result changed while stalled");

    a_warmup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_reg == WCNT_W'(MARKER_PAIRS + 1))
        else $error("result before delay line filled");

    a_sat_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_code == PH_225 |-> out_i != SAMPLE_MIN && out_q != SAMPLE_MIN)
        else $error("negation did not saturate");

endmodule

bind qpsk_asm_phase_resolver qar_checker u_qar_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_i       (results.out_i),
    .out_q       (results.out_q),
    .phase_code  (results.phase_code),
    .frame_first (results.frame_first)
);
